### rtl/rchc_pkg.sv
`timescale 1ns / 1ps

package rchc_pkg;

  // Default table depth
  localparam int SLOTS_DEF = 8;

  // Field widths fixed by the request and result formats
  localparam int CID_W = 17;
  localparam int CS_W  = 24;

  // Register map (index taken from paddr[2])
  localparam logic REG_CHUNK_SIZE = 1'b0;
  localparam logic [CS_W-1:0] CHUNK_SIZE_RST = 24'd128;

  // Protocol constants
  localparam logic [23:0] EXT_LIMIT   = 24'hFFFFFF;
  localparam logic [16:0] BASIC1_LIM  = 17'd64;
  localparam logic [16:0] BASIC2_LIM  = 17'd320;
  localparam logic [4:0]  EXT_BYTES   = 5'd4;

  // Request types
  localparam logic REQ_BIND = 1'b0;
  localparam logic REQ_MSG  = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
  localparam logic [1:0] STATUS_TOO_BIG = 2'd2;

  // Chunk header formats
  localparam logic [1:0] FMT_0 = 2'd0;
  localparam logic [1:0] FMT_1 = 2'd1;
  localparam logic [1:0] FMT_2 = 2'd2;
  localparam logic [1:0] FMT_3 = 2'd3;

  // Chunk count divider: 26-bit dividend, two quotient bits per cycle
  localparam int DIV_W   = 26;
  localparam int DIV_CYC = 13;

  // Request queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;

  typedef struct packed {
    logic        req_type;
    logic [2:0]  slot;
    logic [16:0] stream_cid;
    logic        allow_compress;
    logic [31:0] msg_time;
    logic [23:0] msg_length;
    logic [7:0]  msg_kind;
    logic [31:0] msg_stream;
  } req_t;

  typedef struct packed {
    req_t       req;
    logic [1:0] basic;
    logic       too_big;
  } fq_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  chunk_fmt;
    logic [31:0] time_field;
    logic        extended_time;
    logic [4:0]  first_header_bytes;
    logic [2:0]  next_header_bytes;
    logic [23:0] chunk_count;
  } res_t;

  typedef struct packed {
    logic [1:0]  fmt;
    logic [31:0] time_field;
    logic [23:0] length;
    logic [7:0]  kind;
    logic [31:0] stream;
    logic [31:0] msg_clock;
  } hdr_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MOD,
    F_REM,
    F_PUSH
  } f_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_EVAL,
    B_DIV_INIT,
    B_DIV,
    B_OUT
  } b_state_e;

  // Message header bytes for each format
  function automatic logic [4:0] msg_hdr_bytes(input logic [1:0] fmt);
    logic [4:0] n;
    case (fmt)
      FMT_0:   n = 5'd11;
      FMT_1:   n = 5'd7;
      FMT_2:   n = 5'd3;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

### rtl/rchc_front.sv
`timescale 1ns / 1ps

module rchc_front import rchc_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  req_t             s_req_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output fq_t              push_data_o,
  output logic [IDX_W-1:0] push_start_o
);

  // Scaled reciprocal of SLOTS; the quotient is exact for every 17-bit id
  localparam int RCP_SH = CID_W + $clog2(SLOTS);
  localparam int RCP_W  = CID_W + 1;
  localparam int PROD_W = CID_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP     = RCP_W'(((1 << RCP_SH) + SLOTS - 1) / SLOTS);
  localparam logic [CID_W-1:0] SLOTS_C = CID_W'(SLOTS);

  f_state_e state_q, state_d;
  req_t req_q, req_d;
  logic [CID_W-1:0] quo_q, quo_d;
  logic [IDX_W-1:0] rem_q, rem_d;
  logic [PROD_W-1:0] prod;
  logic [CID_W-1:0] diff;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Request payload and home slot datapath
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  // Home slot: quotient by reciprocal multiply, then the remainder
  assign prod = PROD_W'(req_q.stream_cid) * PROD_W'(RCP);
  assign diff = req_q.stream_cid - quo_q * SLOTS_C;

  // Next state: latch request, reduce stream id mod SLOTS, hand to queue
  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    quo_d        = quo_q;
    rem_d        = rem_q;
    s_ready_o    = 1'b0;
    push_valid_o = 1'b0;
    case (state_q)
      F_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          req_d   = s_req_i;
          state_d = F_MOD;
        end
      end
      F_MOD: begin
        quo_d   = CID_W'(prod >> RCP_SH);
        state_d = F_REM;
      end
      F_REM: begin
        rem_d   = diff[IDX_W-1:0];
        state_d = F_PUSH;
      end
      F_PUSH: begin
        push_valid_o = 1'b1;
        if (push_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  // Classification carried with the request
  always_comb begin
    push_data_o.req     = req_q;
    push_data_o.too_big = (req_q.msg_length >= EXT_LIMIT);
    if (req_q.stream_cid < BASIC1_LIM) begin
      push_data_o.basic = 2'd1;
    end else if (req_q.stream_cid < BASIC2_LIM) begin
      push_data_o.basic = 2'd2;
    end else begin
      push_data_o.basic = 2'd3;
    end
  end

  assign push_start_o = rem_q;

endmodule

### rtl/rchc_fifo.sv
`timescale 1ns / 1ps

module rchc_fifo import rchc_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_PTR_W:0] count_q;
  logic do_push, do_pop;

  assign push_ready_o = (count_q != (Q_PTR_W+1)'(Q_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/rchc_back.sv
`timescale 1ns / 1ps

module rchc_back import rchc_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CS_W-1:0]  chunk_size_i,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  fq_t              pop_data_i,
  input  logic [IDX_W-1:0] pop_start_i,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output res_t             m_res_o
);

  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(SLOTS);
  localparam logic [3:0] DIV_CNT_INIT   = 4'(DIV_CYC);

  b_state_e state_q, state_d;
  fq_t item_q, item_d;
  logic [IDX_W-1:0] idx_q, idx_d, rd_idx_q, rd_idx_d, sel_q, sel_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic pend_q, pend_d;
  logic [1:0] fmt_q, fmt_d;
  logic [31:0] tf_q, tf_d;
  logic [DIV_W-1:0] dvd_q, dvd_d;
  logic [CS_W:0] rem_q, rem_d;
  logic [3:0] dcnt_q, dcnt_d;
  res_t res_q, res_d, out_q, out_d;
  logic out_vld_q, out_vld_d;

  // Slot tables and their valid bits
  logic [CID_W-1:0] id_mem [SLOTS];
  hdr_t hdr_mem [SLOTS];
  logic [SLOTS-1:0] id_vld_q, hdr_vld_q;
  logic [CID_W-1:0] id_rd_q;
  logic id_rd_vld_q;
  hdr_t hdr_rd_q;
  logic hdr_rd_vld_q;

  logic id_re, id_we, hdr_re, hdr_we;
  logic [IDX_W-1:0] id_wr_addr, hdr_rd_addr;
  hdr_t hdr_wdata;
  logic match;
  logic [CS_W-1:0] csz;

  assign csz   = (chunk_size_i == '0) ? CS_W'(1) : chunk_size_i;
  assign match = pend_q && id_rd_vld_q && (id_rd_q == item_q.req.stream_cid)
                 && (item_q.req.stream_cid != '0);
  assign id_wr_addr = IDX_W'(pop_data_i.req.slot);

  // Stream id table
  always_ff @(posedge clk_i) begin
    if (id_we) begin
      id_mem[id_wr_addr] <= pop_data_i.req.stream_cid;
    end
    if (id_re) begin
      id_rd_q     <= id_mem[idx_q];
      id_rd_vld_q <= id_vld_q[idx_q];
    end
  end

  // Header table
  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_mem[sel_q] <= hdr_wdata;
    end
    if (hdr_re) begin
      hdr_rd_q     <= hdr_mem[hdr_rd_addr];
      hdr_rd_vld_q <= hdr_vld_q[hdr_rd_addr];
    end
  end

  // Valid bits: bind marks the id and drops the header, a message sets it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_vld_q  <= '0;
      hdr_vld_q <= '0;
    end else begin
      if (id_we) begin
        id_vld_q[id_wr_addr]  <= 1'b1;
        hdr_vld_q[id_wr_addr] <= 1'b0;
      end
      if (hdr_we) begin
        hdr_vld_q[sel_q] <= 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      pend_q    <= 1'b0;
      cnt_q     <= '0;
      dcnt_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pend_q    <= pend_d;
      cnt_q     <= cnt_d;
      dcnt_q    <= dcnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    idx_q    <= idx_d;
    rd_idx_q <= rd_idx_d;
    sel_q    <= sel_d;
    fmt_q    <= fmt_d;
    tf_q     <= tf_d;
    dvd_q    <= dvd_d;
    rem_q    <= rem_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  // Sequencer: lookup scan, format choice, chunk count divide, result
  always_comb begin
    hdr_t prev;
    logic [31:0] delta;
    logic ext;
    logic [CS_W:0] r;
    logic [DIV_W-1:0] q;
    state_d     = state_q;
    item_d      = item_q;
    idx_d       = idx_q;
    rd_idx_d    = rd_idx_q;
    sel_d       = sel_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    fmt_d       = fmt_q;
    tf_d        = tf_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    dcnt_d      = dcnt_q;
    res_d       = res_q;
    out_d       = out_q;
    out_vld_d   = out_vld_q && !m_ready_i;
    pop_ready_o = 1'b0;
    id_re       = 1'b0;
    id_we       = 1'b0;
    hdr_re      = 1'b0;
    hdr_we      = 1'b0;
    hdr_rd_addr = rd_idx_q;
    prev        = hdr_rd_vld_q ? hdr_rd_q : '0;
    delta       = item_q.req.msg_time - prev.msg_clock;
    hdr_wdata   = '0;
    ext         = (tf_q >= 32'(EXT_LIMIT));
    r           = rem_q;
    q           = dvd_q;
    case (state_q)
      B_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          item_d = pop_data_i;
          if (pop_data_i.req.req_type == REQ_BIND) begin
            id_we   = (32'(pop_data_i.req.slot) < SLOTS);
            res_d   = '0;
            state_d = B_OUT;
          end else begin
            idx_d   = pop_start_i;
            cnt_d   = '0;
            pend_d  = 1'b0;
            state_d = B_SCAN;
          end
        end
      end
      B_SCAN: begin
        if (match) begin
          hdr_re  = 1'b1;
          sel_d   = rd_idx_q;
          pend_d  = 1'b0;
          state_d = B_EVAL;
        end else if (cnt_q < CNT_END) begin
          id_re    = 1'b1;
          rd_idx_d = idx_q;
          idx_d    = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
          cnt_d    = cnt_q + 1'b1;
          pend_d   = 1'b1;
        end else begin
          pend_d       = 1'b0;
          res_d        = '0;
          res_d.status = STATUS_UNKNOWN;
          state_d      = B_OUT;
        end
      end
      B_EVAL: begin
        fmt_d = FMT_0;
        tf_d  = item_q.req.msg_time;
        if (item_q.req.allow_compress && (item_q.req.msg_time >= prev.msg_clock)
            && (delta < 32'(EXT_LIMIT)) && (item_q.req.msg_stream == prev.stream)) begin
          fmt_d = FMT_1;
          tf_d  = delta;
          if ((item_q.req.msg_kind == prev.kind) && (item_q.req.msg_length == prev.length)) begin
            fmt_d = FMT_2;
            if (delta == prev.time_field) begin
              fmt_d = FMT_3;
            end
          end
        end
        hdr_we               = 1'b1;
        hdr_wdata.fmt        = fmt_d;
        hdr_wdata.time_field = tf_d;
        hdr_wdata.length     = item_q.req.msg_length;
        hdr_wdata.kind       = item_q.req.msg_kind;
        hdr_wdata.stream     = item_q.req.msg_stream;
        hdr_wdata.msg_clock  = item_q.req.msg_time;
        if (item_q.too_big) begin
          res_d        = '0;
          res_d.status = STATUS_TOO_BIG;
          state_d      = B_OUT;
        end else begin
          state_d = B_DIV_INIT;
        end
      end
      B_DIV_INIT: begin
        res_d.status             = STATUS_OK;
        res_d.chunk_fmt          = fmt_q;
        res_d.time_field         = tf_q;
        res_d.extended_time      = ext;
        res_d.first_header_bytes = 5'(item_q.basic) + msg_hdr_bytes(fmt_q)
                                   + (ext ? EXT_BYTES : 5'd0);
        res_d.next_header_bytes  = 3'(item_q.basic) + (ext ? 3'(EXT_BYTES) : 3'd0);
        res_d.chunk_count        = '0;
        dvd_d   = DIV_W'(item_q.req.msg_length) + DIV_W'(csz) - DIV_W'(1);
        rem_d   = '0;
        dcnt_d  = DIV_CNT_INIT;
        state_d = B_DIV;
      end
      B_DIV: begin
        // two restoring steps per cycle
        for (int j = 0; j < 2; j++) begin
          r = {r[CS_W-1:0], q[DIV_W-1]};
          q = {q[DIV_W-2:0], 1'b0};
          if (r >= {1'b0, csz}) begin
            r    = r - {1'b0, csz};
            q[0] = 1'b1;
          end
        end
        rem_d  = r;
        dvd_d  = q;
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == 4'd1) begin
          res_d.chunk_count = q[CS_W-1:0];
          state_d = B_OUT;
        end
      end
      B_OUT: begin
        if (!out_vld_q || m_ready_i) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign m_valid_o = out_vld_q;
  assign m_res_o   = out_q;

  // Checks
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_SCAN |-> cnt_q <= CNT_END)
    else $error("scan issued more reads than slots");

  a_ok_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.status == STATUS_OK
    |-> 5'(out_q.next_header_bytes) <= out_q.first_header_bytes)
    else $error("continuation header larger than first header");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.status != STATUS_OK
    |-> out_q.chunk_fmt == FMT_0 && out_q.time_field == '0 && out_q.chunk_count == '0)
    else $error("error result carries nonzero fields");

  a_delta_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.status == STATUS_OK && out_q.chunk_fmt != FMT_0
    |-> !out_q.extended_time)
    else $error("compressed header with extended timestamp");

  a_msg_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_IDLE && pop_valid_i && pop_data_i.req.req_type == REQ_MSG
    |=> state_q == B_SCAN && cnt_q == '0)
    else $error("message request did not start a lookup");

endmodule

### rtl/rtmp_chunk_header_compressor.sv
`timescale 1ns / 1ps

// Chunk header compressor for an RTMP sender.
// Requests enter on the s_axis channel: tuser = req_type (0 bind, 1 message),
// tdata carries the rest. A bind loads a chunk stream id into a table slot and
// clears that slot's header; a message looks its id up, picks chunk format 0..3,
// updates the slot and returns timestamp field, header byte counts and chunk count.
// Every request gives exactly one result on m_axis (tuser = status).
// chunk_size is written over APB at address 0; the user must write it only while
// the block is idle; the block itself does not enforce this. For each request the
// front finds the home slot by reciprocal multiply and remainder and hands the
// request to the queue; the back pops it, probes the id table from the home slot
// (a miss probes every slot), reads the header and chooses the format, runs the
// chunk count divider (two quotient bits a cycle) and loads the output register.
// A bind, a failed lookup or a rejected length skips the divider.
// Requests are handled one at a time in the back; a two-entry queue lets the
// front take the next request meanwhile.
// Reset empties every slot, sets chunk_size to 128 and needs no clearing pass.
// A stalled receiver holds the result in the output register; the back waits
// with its next result, the queue fills, the front holds its request and
// s_axis_tready_o stays low.
module rtmp_chunk_header_compressor import rchc_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // slot[2:0], stream_cid[19:3], allow_compress[20], msg_time[52:21],
  // msg_length[76:53], msg_kind[84:77], msg_stream[116:85]
  input  logic [119:0] s_axis_tdata_i,
  // req_type[0]
  input  logic         s_axis_tuser_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // chunk_fmt[1:0], time_field[33:2], extended_time[34],
  // first_header_bytes[39:35], next_header_bytes[42:40], chunk_count[66:43]
  output logic [71:0]  m_axis_tdata_o,
  // status[1:0]
  output logic [1:0]   m_axis_tuser_o,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int QW    = $bits(fq_t) + IDX_W;

  logic [CS_W-1:0] chunk_size_q;
  req_t s_req;
  fq_t push_data, pop_data;
  logic [IDX_W-1:0] push_start, pop_start;
  logic push_valid, push_ready, pop_valid, pop_ready;
  logic [QW-1:0] q_pop;
  res_t res;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CHUNK_SIZE) ? {8'd0, chunk_size_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_size_q <= CHUNK_SIZE_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CHUNK_SIZE)) begin
      chunk_size_q <= pwdata[CS_W-1:0];
    end
  end

  // Request unpacking
  assign s_req.req_type       = s_axis_tuser_i;
  assign s_req.slot           = s_axis_tdata_i[2:0];
  assign s_req.stream_cid     = s_axis_tdata_i[19:3];
  assign s_req.allow_compress = s_axis_tdata_i[20];
  assign s_req.msg_time       = s_axis_tdata_i[52:21];
  assign s_req.msg_length     = s_axis_tdata_i[76:53];
  assign s_req.msg_kind       = s_axis_tdata_i[84:77];
  assign s_req.msg_stream     = s_axis_tdata_i[116:85];

  rchc_front #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .s_req_i      (s_req),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data),
    .push_start_o (push_start)
  );

  rchc_fifo #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_start, push_data}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (q_pop)
  );

  assign pop_data  = q_pop[$bits(fq_t)-1:0];
  assign pop_start = q_pop[QW-1:$bits(fq_t)];

  rchc_back #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .chunk_size_i (chunk_size_q),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_data_i   (pop_data),
    .pop_start_i  (pop_start),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .m_res_o      (res)
  );

  // Result packing
  assign m_axis_tuser_o  = res.status;
  assign m_axis_tdata_o  = {5'd0, res.chunk_count, res.next_header_bytes,
                            res.first_header_bytes, res.extended_time,
                            res.time_field, res.chunk_fmt};

endmodule

### sim/rtmp_chunk_header_compressor_tb.sv
`timescale 1ns / 1ps

module rtmp_chunk_header_compressor_tb;
  import rchc_pkg::*;

  localparam int NSLOT = SLOTS_DEF;
  localparam int SLOT_W = $clog2(NSLOT);
  localparam logic [2:0] CHUNK_SIZE_ADDR = {REG_CHUNK_SIZE, 2'b00};

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  // slot, stream_cid, allow_compress, msg_time, msg_length, msg_kind, msg_stream
  logic [119:0] s_axis_tdata_i = '0;
  // req_type
  logic         s_axis_tuser_i = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  // chunk_fmt, time_field, extended_time, first_header_bytes,
  // next_header_bytes, chunk_count
  logic [71:0]  m_axis_tdata_o;
  // status
  logic [1:0]   m_axis_tuser_o;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  // Predicted chunk stream table and register
  logic [16:0]  bound_cid [NSLOT];
  hdr_t         slot_hdr [NSLOT];
  logic [23:0]  chunk_size_q;

  res_t         header_results_q [$];
  int unsigned  mismatch_count = 0;
  bit           idle_on = 1'b1;

  rtmp_chunk_header_compressor u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #6 clk_i = ~clk_i;

  // Header compression as the block should do it; updates the table
  function automatic res_t compress_header(input req_t r);
    res_t        o;
    hdr_t        h;
    bit          hit;
    logic [SLOT_W-1:0] hit_slot;
    logic [SLOT_W-1:0] probe;
    logic [1:0]  fmt;
    logic [31:0] tf;
    logic        ext;
    logic [4:0]  basic;
    logic [4:0]  msgh;
    logic [31:0] csz;
    o = '0;
    if (r.req_type == REQ_BIND) begin
      bound_cid[r.slot] = r.stream_cid;
      slot_hdr[r.slot] = '0;
      return o;
    end
    // search starts at the home slot and wraps; id zero marks an empty slot
    hit = 1'b0;
    hit_slot = '0;
    if (r.stream_cid != '0) begin
      for (int i = 0; i < NSLOT; i++) begin
        probe = SLOT_W'((32'(r.stream_cid) + 32'(i)) % NSLOT);
        if (!hit && bound_cid[probe] == r.stream_cid) begin
          hit = 1'b1;
          hit_slot = probe;
        end
      end
    end
    if (!hit) begin
      o.status = STATUS_UNKNOWN;
      return o;
    end
    h = slot_hdr[hit_slot];
    fmt = FMT_0;
    tf = r.msg_time;
    if (r.allow_compress && r.msg_time >= h.msg_clock &&
        (r.msg_time - h.msg_clock) < {8'h00, EXT_LIMIT} && r.msg_stream == h.stream) begin
      fmt = FMT_1;
      tf = r.msg_time - h.msg_clock;
      if (r.msg_kind == h.kind && r.msg_length == h.length) begin
        fmt = FMT_2;
        if (tf == h.time_field) fmt = FMT_3;
      end
    end
    // entry is updated even when the length is rejected
    h.fmt = fmt;
    h.time_field = tf;
    h.length = r.msg_length;
    h.kind = r.msg_kind;
    h.stream = r.msg_stream;
    h.msg_clock = r.msg_time;
    slot_hdr[hit_slot] = h;
    if (r.msg_length >= EXT_LIMIT) begin
      o.status = STATUS_TOO_BIG;
      return o;
    end
    ext = (tf >= {8'h00, EXT_LIMIT});
    if (r.stream_cid < BASIC1_LIM) basic = 5'd1;
    else if (r.stream_cid < BASIC2_LIM) basic = 5'd2;
    else basic = 5'd3;
    case (fmt)
      FMT_0:   msgh = 5'd11;
      FMT_1:   msgh = 5'd7;
      FMT_2:   msgh = 5'd3;
      default: msgh = 5'd0;
    endcase
    csz = (chunk_size_q == '0) ? 32'd1 : {8'h00, chunk_size_q};
    o.status = STATUS_OK;
    o.chunk_fmt = fmt;
    o.time_field = tf;
    o.extended_time = ext;
    o.first_header_bytes = basic + msgh + (ext ? EXT_BYTES : 5'd0);
    o.next_header_bytes = 3'(basic + (ext ? EXT_BYTES : 5'd0));
    o.chunk_count = 24'(({8'h00, r.msg_length} + csz - 32'd1) / csz);
    return o;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (header_results_q.size() == 0) begin
        $error("result with no request outstanding: status %0d data 0x%0h",
               m_axis_tuser_o, m_axis_tdata_o);
        mismatch_count++;
      end else begin
        want = header_results_q.pop_front();
        check_field("status", 32'(want.status), 32'(m_axis_tuser_o));
        check_field("chunk_fmt", 32'(want.chunk_fmt), 32'(m_axis_tdata_o[1:0]));
        check_field("time_field", want.time_field, m_axis_tdata_o[33:2]);
        check_field("extended_time", 32'(want.extended_time), 32'(m_axis_tdata_o[34]));
        check_field("first_header_bytes", 32'(want.first_header_bytes),
                    32'(m_axis_tdata_o[39:35]));
        check_field("next_header_bytes", 32'(want.next_header_bytes),
                    32'(m_axis_tdata_o[42:40]));
        check_field("chunk_count", 32'(want.chunk_count), 32'(m_axis_tdata_o[66:43]));
      end
    end
  end

  // Result side backpressure
  always @(negedge clk_i) begin
    m_axis_tready_i <= idle_on ? ($urandom_range(99) >= 33) : 1'b1;
  end

  // Send one request; valid stays high between back-to-back requests
  task automatic send_request(input req_t r);
    int unsigned gap;
    @(negedge clk_i);
    if (idle_on && $urandom_range(99) < 33) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata_i <= {3'b000, r.msg_stream, r.msg_kind, r.msg_length, r.msg_time,
                       r.allow_compress, r.stream_cid, r.slot};
    s_axis_tuser_i <= r.req_type;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    header_results_q.push_back(compress_header(r));
  endtask

  task automatic send_bind(input logic [2:0] slot, input logic [16:0] cid);
    req_t r;
    r = '0;
    r.req_type = REQ_BIND;
    r.slot = slot;
    r.stream_cid = cid;
    send_request(r);
  endtask

  task automatic send_msg(input logic [16:0] cid, input logic allow, input logic [31:0] t,
                          input logic [23:0] len, input logic [7:0] kind,
                          input logic [31:0] stream);
    req_t r;
    r = '0;
    r.req_type = REQ_MSG;
    r.stream_cid = cid;
    r.allow_compress = allow;
    r.msg_time = t;
    r.msg_length = len;
    r.msg_kind = kind;
    r.msg_stream = stream;
    send_request(r);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (header_results_q.size() != 0) @(posedge clk_i);
  endtask

  // Register write followed by a read back; only while idle
  task automatic write_chunk_size(input logic [23:0] v);
    drain();
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CHUNK_SIZE_ADDR;
    pwdata <= {8'h00, v};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    chunk_size_q = v;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("prdata", {8'h00, v}, prdata);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [16:0] rand_cid();
    case ($urandom_range(3))
      0:       return 17'($urandom_range(2, 63));
      1:       return 17'($urandom_range(64, 319));
      2:       return 17'($urandom_range(320, 65599));
      default: return 17'($urandom_range(0, 17'h1FFFF));
    endcase
  endfunction

  function automatic logic [23:0] rand_length();
    case ($urandom_range(19))
      0:       return EXT_LIMIT;
      1, 2:    return 24'($urandom_range(0, 24'hFFFFFF));
      default: return 24'($urandom_range(0, 1500));
    endcase
  endfunction

  // Mostly follow-on messages on bound streams, some binds and noise
  task automatic send_random_request();
    req_t        r;
    hdr_t        h;
    int unsigned pick;
    logic [SLOT_W-1:0] s;
    pick = $urandom_range(99);
    s = SLOT_W'($urandom_range(NSLOT - 1));
    h = slot_hdr[s];
    r.req_type = (pick < 8) ? REQ_BIND : REQ_MSG;
    r.slot = 3'($urandom);
    r.stream_cid = (pick >= 8 && pick < 90) ? bound_cid[s] : rand_cid();
    r.allow_compress = ($urandom_range(9) != 0);
    r.msg_stream = ($urandom_range(9) != 0) ? h.stream : $urandom;
    if ($urandom_range(1)) begin
      r.msg_kind = h.kind;
      r.msg_length = h.length;
    end else begin
      r.msg_kind = 8'($urandom);
      r.msg_length = rand_length();
    end
    case ($urandom_range(9))
      0:       r.msg_time = $urandom;
      1:       r.msg_time = h.msg_clock - $urandom_range(1, 100);
      2:       r.msg_time = h.msg_clock + 32'h00FFFFFF - $urandom_range(0, 1);
      3, 4, 5: r.msg_time = h.msg_clock + h.time_field;
      default: r.msg_time = h.msg_clock + $urandom_range(0, 200);
    endcase
    send_request(r);
  endtask

  // Lookups against the empty table after reset
  task automatic test_empty_table();
    send_msg(17'd5, 1'b1, 32'd0, 24'd10, 8'd9, 32'd0);
    send_msg(17'd0, 1'b1, 32'd0, 24'd0, 8'd0, 32'd0);
  endtask

  // Format choice, basic header sizes, extended time, lookup order
  task automatic test_formats();
    send_bind(3'd5, 17'd5);
    send_msg(17'd5, 1'b0, 32'd1000, 24'd300, 8'd9, 32'd1);
    send_msg(17'd5, 1'b1, 32'd1040, 24'd300, 8'd9, 32'd1);
    send_msg(17'd5, 1'b1, 32'd1080, 24'd300, 8'd9, 32'd1);
    send_msg(17'd5, 1'b1, 32'd1120, 24'd128, 8'd9, 32'd1);
    // clock going backwards, then a new message stream
    send_msg(17'd5, 1'b1, 32'd1100, 24'd128, 8'd9, 32'd1);
    send_msg(17'd5, 1'b1, 32'd1200, 24'd128, 8'd9, 32'd2);
    // delta exactly at the extended limit falls back to format 0
    send_msg(17'd5, 1'b1, 32'd1200 + 32'h00FFFFFF, 24'd128, 8'd9, 32'd2);
    // fresh slot compares against a zero header; reached by wrapping search
    send_bind(3'd1, 17'd63);
    send_msg(17'd63, 1'b1, 32'd0, 24'd0, 8'd0, 32'd0);
    send_bind(3'd2, 17'd64);
    send_msg(17'd64, 1'b0, 32'hFFFFFFFF, 24'd1, 8'd0, 32'd0);
    send_bind(3'd3, 17'd319);
    send_msg(17'd319, 1'b1, 32'h00FFFFFE, 24'd0, 8'd0, 32'd0);
    send_bind(3'd4, 17'd320);
    send_msg(17'd320, 1'b1, 32'd7, EXT_LIMIT, 8'd20, 32'd0);
    send_msg(17'd320, 1'b1, 32'd14, EXT_LIMIT - 24'd1, 8'd20, 32'd0);
    send_bind(3'd0, 17'h1FFFF);
    send_msg(17'h1FFFF, 1'b0, 32'hFFFFFFFF, 24'hFFFFFE, 8'hFF, 32'hFFFFFFFF);
    // same id in two slots: the home slot wins until it is rebound
    send_bind(3'd6, 17'd14);
    send_bind(3'd7, 17'd14);
    send_msg(17'd14, 1'b1, 32'd50, 24'd60, 8'd8, 32'd0);
    send_bind(3'd6, 17'd30);
    send_msg(17'd14, 1'b1, 32'd50, 24'd60, 8'd8, 32'd0);
  endtask

  // Chunk count across register settings, zero included
  task automatic test_chunk_size();
    write_chunk_size(24'd1);
    send_msg(17'd5, 1'b1, 32'd3000, 24'd0, 8'd9, 32'd1);
    send_msg(17'd5, 1'b1, 32'd3010, 24'd1, 8'd9, 32'd1);
    send_msg(17'd5, 1'b1, 32'd3020, 24'd1500, 8'd9, 32'd1);
    write_chunk_size(24'hFFFFFF);
    send_msg(17'd5, 1'b1, 32'd3030, 24'hFFFFFE, 8'd9, 32'd1);
    send_msg(17'd5, 1'b1, 32'd3040, 24'd1, 8'd9, 32'd1);
    write_chunk_size(24'd0);
    send_msg(17'd5, 1'b1, 32'd3050, 24'd7, 8'd9, 32'd1);
    write_chunk_size(24'd129);
    send_msg(17'd5, 1'b1, 32'd3060, 24'd258, 8'd9, 32'd1);
    send_msg(17'd5, 1'b1, 32'd3070, 24'd259, 8'd9, 32'd1);
  endtask

  // Random requests over several chunk sizes; one phase without idling
  task automatic test_random();
    logic [23:0] sizes [6];
    sizes = '{24'd128, 24'd1, 24'd4096, 24'($urandom_range(1, 24'hFFFFFF)),
              24'hFFFFFF, 24'($urandom_range(1, 300))};
    for (int p = 0; p < 6; p++) begin
      write_chunk_size(sizes[3'(p)]);
      idle_on = (p != 2);
      if (p == 0) begin
        for (int s = 0; s < NSLOT; s++) send_bind(3'(s), rand_cid());
      end
      for (int n = 0; n < 95; n++) send_random_request();
    end
    idle_on = 1'b1;
  endtask

  // Sender holds off until the block has emptied, then resumes
  task automatic test_pressure();
    for (int k = 0; k < 3; k++) begin
      for (int n = 0; n < 10; n++) send_random_request();
      drain();
    end
  endtask

  initial begin
    foreach (bound_cid[s]) begin
      bound_cid[s] = '0;
      slot_hdr[s] = '0;
    end
    chunk_size_q = CHUNK_SIZE_RST;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_table();
    test_formats();
    test_chunk_size();
    test_random();
    test_pressure();

    drain();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("rtmp_chunk_header_compressor verification clean");
    end else begin
      $display("rtmp_chunk_header_compressor verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("rtmp_chunk_header_compressor verification failed");
    $finish;
  end

endmodule

### files.f
rtl/rchc_pkg.sv
rtl/rchc_front.sv
rtl/rchc_fifo.sv
rtl/rchc_back.sv
rtl/rtmp_chunk_header_compressor.sv
sim/rtmp_chunk_header_compressor_tb.sv
